// ----- rtl/core/uri_percent_encoder_assert.svh -----
// ----------------------------------------------------------------------------
// URI percent encoder assertion macros
// Concurrent assertion wrappers; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef URI_PERCENT_ENCODER_ASSERT_SVH
`define URI_PERCENT_ENCODER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define UPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define UPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UPE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define UPE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/core/upe_pkg.sv -----
// ----------------------------------------------------------------------------
// URI percent encoder package
// Character constants, classification helpers and the job record that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package upe_pkg;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [3:0] NIB_MASK = 4'hf;

	// Register indexes of the configuration port
	localparam logic REG_ALLOW_SLASH = 1'b0;
	localparam logic REG_KEEP_PCT    = 1'b1;

	// Bytes emitted ahead of the current byte, resolving a held escape
	typedef enum logic [1:0] {
		PRE_NONE    = 2'd0, // nothing held before
		PRE_PCT     = 2'd1, // broken escape: "%25"
		PRE_PCT_DIG = 2'd2, // broken escape: "%25" and the held digit
		PRE_TRIP    = 2'd3  // complete escape: '%', held digit, current byte
	} pre_kind_t;

	// Treatment of the current byte itself
	typedef enum logic [1:0] {
		FR_NONE = 2'd0, // consumed by a complete escape
		FR_PASS = 2'd1, // copied unchanged
		FR_ESC  = 2'd2, // emitted as '%' and two hex digits
		FR_HOLD = 2'd3  // '%' held back, nothing emitted yet
	} fresh_kind_t;

	typedef struct packed {
		pre_kind_t   pre;
		fresh_kind_t fresh;
		logic [7:0]  held;
		logic [7:0]  cur;
		logic        last;
	} job_t;

	function automatic logic is_hex(input logic [7:0] c);
		return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic is_unreserved(input logic [7:0] c);
		return c inside {[8'h41:8'h5a], [8'h61:8'h7a], [8'h30:8'h39],
			8'h2d, 8'h2e, 8'h5f, 8'h7e};
	endfunction

	// Upper-case hex digit of a nibble
	function automatic logic [7:0] hex_up(input logic [3:0] n);
		logic [7:0] r;
		if (n < 4'd10) begin
			r = 8'h30 + {4'h0, n};
		end else begin
			r = 8'h37 + {4'h0, n};
		end
		return r;
	endfunction

endpackage

// ----- rtl/core/upe_front.sv -----
// ----------------------------------------------------------------------------
// URI percent encoder front end
// Accepts input bytes, tracks a held '%' and hex digit, and turns each byte
// into a job record for the back end.
// ----------------------------------------------------------------------------
`include "uri_percent_encoder_assert.svh"

module upe_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          allow_slash,
	input  logic          keep_pct_encoded,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    in_byte,
	input  logic          in_last,
	input  logic          q_ready,
	output logic          q_push,
	output upe_pkg::job_t q_job
);
	import upe_pkg::*;

	logic [1:0]  held_cnt_q;
	logic [7:0]  held_char_q;
	logic [1:0]  held_cnt_d;
	logic [7:0]  held_char_d;
	fresh_kind_t fr_kind;
	logic        accept;

	assign in_ready = q_ready;
	assign accept   = in_valid && in_ready;

	// Classify the current byte as if nothing were held
	always_comb begin
		if ((allow_slash && in_byte == CH_SLASH) || is_unreserved(in_byte)) begin
			fr_kind = FR_PASS;
		end else if (keep_pct_encoded && in_byte == CH_PCT && !in_last) begin
			fr_kind = FR_HOLD;
		end else begin
			fr_kind = FR_ESC;
		end
	end

	// Resolve the held escape against the current byte
	always_comb begin
		q_job.pre   = PRE_NONE;
		q_job.fresh = fr_kind;
		q_job.held  = held_char_q;
		q_job.cur   = in_byte;
		q_job.last  = in_last;
		held_char_d = held_char_q;
		held_cnt_d  = (fr_kind == FR_HOLD) ? 2'd1 : 2'd0;
		case (held_cnt_q)
			2'd1: begin
				if (is_hex(in_byte) && !in_last) begin
					q_job.fresh = FR_NONE;
					held_cnt_d  = 2'd2;
					held_char_d = in_byte;
				end else begin
					q_job.pre = PRE_PCT;
				end
			end
			2'd2: begin
				held_char_d = '0;
				if (is_hex(in_byte)) begin
					q_job.pre   = PRE_TRIP;
					q_job.fresh = FR_NONE;
					held_cnt_d  = 2'd0;
				end else begin
					q_job.pre = PRE_PCT_DIG;
				end
			end
			default: begin
				q_job.pre = PRE_NONE;
			end
		endcase
	end

	// Drop jobs that emit nothing
	assign q_push = accept &&
		!(q_job.pre == PRE_NONE && (q_job.fresh == FR_NONE || q_job.fresh == FR_HOLD));

	// Advance the hold state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q  <= 2'd0;
			held_char_q <= '0;
		end else if (accept) begin
			held_cnt_q  <= held_cnt_d;
			held_char_q <= held_char_d;
		end
	end

	`UPE_ASSERT_NXT(a_last_clears_hold, clk, arst_n, accept && in_last,
		held_cnt_q == 2'd0, "hold left pending after string end")
	`UPE_ASSERT_IMP(a_hold_needs_no_push, clk, arst_n, accept && !q_push,
		!in_last, "last item produced no output")

endmodule

// ----- rtl/core/upe_queue.sv -----
// ----------------------------------------------------------------------------
// URI percent encoder job queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`include "uri_percent_encoder_assert.svh"

module upe_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  upe_pkg::job_t push_job,
	output logic          not_full,
	input  logic          pop,
	output logic          not_empty,
	output upe_pkg::job_t head_job
);
	import upe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign not_full  = (cnt_q != CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_job  = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`UPE_ASSERT_IMP(a_no_push_full, clk, arst_n, push,
		cnt_q != CNT_W'(DEPTH), "push into full job queue")
	`UPE_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop,
		cnt_q != '0, "pop from empty job queue")

endmodule

// ----- rtl/core/upe_back.sv -----
// ----------------------------------------------------------------------------
// URI percent encoder back end
// Expands the head job into output bytes, one per cycle while out_ready is
// high, through a registered output stage.
// ----------------------------------------------------------------------------
`include "uri_percent_encoder_assert.svh"

module upe_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  upe_pkg::job_t head_job,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last,
	output logic          string_end
);
	import upe_pkg::*;

	logic [2:0] step_q;
	logic       oval_q;
	logic [7:0] obyte_q;
	logic       orun_q;
	logic       oend_q;
	logic [2:0] pre_len;
	logic [2:0] fr_len;
	logic [2:0] n_len;
	logic [2:0] fr_idx;
	logic [7:0] sel_byte;
	logic       last_step;
	logic       adv;
	logic       take;

	// Size the job
	always_comb begin
		case (head_job.pre)
			PRE_PCT:     pre_len = 3'd3;
			PRE_PCT_DIG: pre_len = 3'd4;
			PRE_TRIP:    pre_len = 3'd3;
			default:     pre_len = 3'd0;
		endcase
		case (head_job.fresh)
			FR_PASS: fr_len = 3'd1;
			FR_ESC:  fr_len = 3'd3;
			default: fr_len = 3'd0;
		endcase
		n_len     = pre_len + fr_len;
		fr_idx    = step_q - pre_len;
		last_step = (step_q == n_len - 3'd1);
	end

	// Pick the byte for this step
	always_comb begin
		sel_byte = '0;
		if (step_q < pre_len) begin
			case (head_job.pre)
				PRE_TRIP: begin
					case (step_q)
						3'd0:    sel_byte = CH_PCT;
						3'd1:    sel_byte = head_job.held;
						default: sel_byte = head_job.cur;
					endcase
				end
				default: begin
					case (step_q)
						3'd0:    sel_byte = CH_PCT;
						3'd1:    sel_byte = CH_TWO;
						3'd2:    sel_byte = CH_FIVE;
						default: sel_byte = head_job.held;
					endcase
				end
			endcase
		end else begin
			case (head_job.fresh)
				FR_ESC: begin
					case (fr_idx)
						3'd0:    sel_byte = CH_PCT;
						3'd1:    sel_byte = hex_up(head_job.cur[7:4]);
						default: sel_byte = hex_up(head_job.cur[3:0] & NIB_MASK);
					endcase
				end
				default: sel_byte = head_job.cur;
			endcase
		end
	end

	assign adv  = !oval_q || out_ready;
	assign take = adv && head_valid;
	assign pop  = take && last_step;

	// Advance the step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (adv) begin
				oval_q <= head_valid;
			end
			if (take) begin
				step_q <= last_step ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	// Load the output payload
	always_ff @(posedge clk) begin
		if (take) begin
			obyte_q <= sel_byte;
			orun_q  <= last_step;
			oend_q  <= last_step && head_job.last;
		end
	end

	assign out_valid  = oval_q;
	assign out_byte   = obyte_q;
	assign run_last   = orun_q;
	assign string_end = oend_q;

	`UPE_ASSERT_IMP(a_step_in_job, clk, arst_n, head_valid,
		step_q < n_len, "expansion step beyond job length")

endmodule

// ----- rtl/core/uri_percent_encoder.sv -----
// ----------------------------------------------------------------------------
// URI percent encoder
// Streaming RFC 3986 percent-encoder with optional slash pass-through and
// preservation of existing escape triplets.
// ----------------------------------------------------------------------------
// Each result byte is emitted from the back end's output register at one
// byte per cycle while out_ready is high; a byte that passes unchanged
// yields one result byte, an escaped byte three, a completed escape triplet
// three, and a broken triplet followed by an escaped byte up to seven. The
// front end classifies an input item in the cycle it is accepted and keeps
// accepting while the job queue (QUEUE_DEPTH entries) has room, so a stream
// of escaped bytes is held back by the back end and plain bytes run at one
// per cycle while out_ready is high. A held '%' or '%' plus digit produces
// no output until the next item resolves it; an item marked last always
// flushes the hold and its final result carries string_end. An item's job
// passes through the job queue, and its first result byte through the back
// end's output register, before that byte is offered on the outputs.
// Configuration is taken over a 32-bit APB-style port: allow_slash at
// address 0, keep_pct_encoded at address 4.
// ----------------------------------------------------------------------------
module uri_percent_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// input bytes
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	// encoded bytes
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        run_last,
	output logic        string_end
);
	import upe_pkg::*;

	logic allow_slash_q;
	logic keep_pct_q;
	logic cfg_wr;
	logic q_ready;
	logic q_push;
	logic q_pop;
	logic q_nempty;
	job_t push_job;
	job_t head_job;

	// Configuration registers
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allow_slash_q <= 1'b0;
			keep_pct_q    <= 1'b0;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ALLOW_SLASH) begin
				allow_slash_q <= pwdata[0];
			end else begin
				keep_pct_q <= pwdata[0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_KEEP_PCT) ? {31'b0, keep_pct_q} : {31'b0, allow_slash_q};

	upe_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.allow_slash      (allow_slash_q),
		.keep_pct_encoded (keep_pct_q),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.in_byte          (in_byte),
		.in_last          (in_last),
		.q_ready          (q_ready),
		.q_push           (q_push),
		.q_job            (push_job)
	);

	upe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.not_full  (q_ready),
		.pop       (q_pop),
		.not_empty (q_nempty),
		.head_job  (head_job)
	);

	upe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_nempty),
		.head_job   (head_job),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule
